// ===== hw/rtl/mie_pkg.sv =====
`timescale 1ns / 1ps
package mie_pkg;

    localparam logic [3:0] MODE_MULT  = 4'd0;
    localparam logic [3:0] MODE_MULTU = 4'd1;
    localparam logic [3:0] MODE_DIV   = 4'd2;
    localparam logic [3:0] MODE_DIVU  = 4'd3;
    localparam logic [3:0] MODE_ADD   = 4'd4;
    localparam logic [3:0] MODE_ADDU  = 4'd5;
    localparam logic [3:0] MODE_SUB   = 4'd6;
    localparam logic [3:0] MODE_SUBU  = 4'd7;
    localparam logic [3:0] MODE_ORI   = 4'd8;
    localparam logic [3:0] MODE_XORI  = 4'd9;
    localparam logic [3:0] MODE_SLT   = 4'd10;
    localparam logic [3:0] MODE_SLL   = 4'd11;
    localparam logic [3:0] MODE_SRL   = 4'd12;
    localparam logic [3:0] MODE_SRA   = 4'd13;
    localparam logic [3:0] MODE_SLLV  = 4'd14;
    localparam logic [3:0] MODE_SRLV  = 4'd15;

    // one quotient bit per divide stage of the back end
    localparam int DIV_STEPS = 32;

    typedef enum logic [1:0] {
        KIND_ALU,
        KIND_MUL,
        KIND_DIV
    } op_kind_t;

    // classified item, front to back
    typedef struct packed {
        op_kind_t    kind;
        logic        is_signed;
        logic        dest_is_rt;
        logic [31:0] a;
        logic [31:0] b;
        logic [63:0] value;
    } fe_item_t;

    // one stage of the back-end pipeline
    typedef struct packed {
        op_kind_t    kind;
        logic        dest_is_rt;
        logic        neg_q;
        logic        neg_r;
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] dvs;
        logic [63:0] value;
    } be_stage_t;

    // finished result item
    typedef struct packed {
        logic [63:0] result;
        logic        write_result;
        logic        dest_is_rt;
        logic        write_lohi;
        logic [63:0] lo_value;
        logic [63:0] hi_value;
    } res_item_t;

    function automatic logic [63:0] sext32(input logic [31:0] w);
        return {{32{w[31]}}, w};
    endfunction

    // one restoring division step
    function automatic be_stage_t div_step(input be_stage_t s);
        be_stage_t   o;
        logic [32:0] trial;
        o = s;
        trial = {s.rem, s.quo[31]};
        if (trial >= {1'b0, s.dvs})
        begin
            o.rem = 32'(trial - {1'b0, s.dvs});
            o.quo = {s.quo[30:0], 1'b1};
        end
        else
        begin
            o.rem = trial[31:0];
            o.quo = {s.quo[30:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ===== hw/rtl/mie_fifo.sv =====
`timescale 1ns / 1ps
module mie_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rd_data,
    output logic         empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_data;
    end
endmodule

// ===== hw/rtl/mie_front.sv =====
`timescale 1ns / 1ps
module mie_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         mode,
    input  logic signed [63:0] rs_value,
    input  logic signed [63:0] rt_value,
    input  logic [4:0]         shift_amount,
    input  logic [15:0]        immediate,
    output logic               q_push,
    output mie_pkg::fe_item_t  q_data,
    input  logic               q_full
);
    logic              valid_reg, valid_next;
    mie_pkg::fe_item_t item_reg, item_next;
    logic [31:0]       a, b;
    logic [4:0]        vsh;
    logic              take;

    assign a    = rs_value[31:0];
    assign b    = rt_value[31:0];
    assign vsh  = rs_value[4:0];
    assign full = valid_reg && q_full;
    assign take = push && !full;

    assign q_push = valid_reg;
    assign q_data = item_reg;

    // classify and do all operations but multiply and divide here
    always_comb
    begin
        item_next            = '0;
        item_next.kind       = mie_pkg::KIND_ALU;
        item_next.a          = a;
        item_next.b          = b;
        unique case (mode)
            mie_pkg::MODE_MULT, mie_pkg::MODE_MULTU:
            begin
                item_next.kind      = mie_pkg::KIND_MUL;
                item_next.is_signed = (mode == mie_pkg::MODE_MULT);
            end
            mie_pkg::MODE_DIV, mie_pkg::MODE_DIVU:
            begin
                item_next.kind      = mie_pkg::KIND_DIV;
                item_next.is_signed = (mode == mie_pkg::MODE_DIV);
            end
            mie_pkg::MODE_ADD, mie_pkg::MODE_ADDU:
                item_next.value = mie_pkg::sext32(a + b);
            mie_pkg::MODE_SUB, mie_pkg::MODE_SUBU:
                item_next.value = mie_pkg::sext32(a - b);
            mie_pkg::MODE_ORI:
            begin
                item_next.value      = rs_value | {48'd0, immediate};
                item_next.dest_is_rt = 1'b1;
            end
            mie_pkg::MODE_XORI:
            begin
                item_next.value      = rs_value ^ {48'd0, immediate};
                item_next.dest_is_rt = 1'b1;
            end
            mie_pkg::MODE_SLT:
                item_next.value = {63'd0, (rs_value < rt_value)};
            mie_pkg::MODE_SLL:
                item_next.value = mie_pkg::sext32(b << shift_amount);
            mie_pkg::MODE_SRL:
                item_next.value = mie_pkg::sext32(b >> shift_amount);
            mie_pkg::MODE_SRA:
                item_next.value = mie_pkg::sext32(32'($signed(b) >>> shift_amount));
            mie_pkg::MODE_SLLV:
                item_next.value = mie_pkg::sext32(b << vsh);
            mie_pkg::MODE_SRLV:
                item_next.value = mie_pkg::sext32(b >> vsh);
            default:
                item_next.value = '0;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (valid_reg && !q_full)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end
endmodule

// ===== hw/rtl/mie_back.sv =====
`timescale 1ns / 1ps
module mie_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  mie_pkg::fe_item_t  q_data,
    output logic               q_pop,
    output logic               r_push,
    output mie_pkg::res_item_t r_data,
    input  logic               r_full
);
    localparam int N = mie_pkg::DIV_STEPS;

    logic                valid_reg [N+1];
    mie_pkg::be_stage_t  stage_reg [N+1];
    mie_pkg::be_stage_t  prep;
    mie_pkg::be_stage_t  last;
    logic                advance;
    logic                na, nb;
    logic signed [65:0]  prod;
    logic [31:0]         q, r;

    // whole pipe moves together; stalls only when the result queue is full
    assign advance = !r_full;
    assign q_pop   = advance && !q_empty;

    always_comb
    begin
        na   = q_data.is_signed && q_data.a[31];
        nb   = q_data.is_signed && q_data.b[31];
        prod = $signed({q_data.is_signed && q_data.a[31], q_data.a})
             * $signed({q_data.is_signed && q_data.b[31], q_data.b});
        prep            = '0;
        prep.kind       = q_data.kind;
        prep.dest_is_rt = q_data.dest_is_rt;
        prep.neg_q      = na ^ nb;
        prep.neg_r      = na;
        prep.quo        = na ? 32'(-q_data.a) : q_data.a;
        prep.dvs        = nb ? 32'(-q_data.b) : q_data.b;
        prep.value      = (q_data.kind == mie_pkg::KIND_MUL) ? prod[63:0] : q_data.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= !q_empty;
            for (int k = 0; k < N; k++)
                valid_reg[k+1] <= valid_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg[0] <= prep;
            for (int k = 0; k < N; k++)
                stage_reg[k+1] <= mie_pkg::div_step(stage_reg[k]);
        end
    end

    assign last   = stage_reg[N];
    assign r_push = valid_reg[N] && advance;
    assign q      = last.neg_q ? 32'(-last.quo) : last.quo;
    assign r      = last.neg_r ? 32'(-last.rem) : last.rem;

    always_comb
    begin
        r_data            = '0;
        r_data.dest_is_rt = last.dest_is_rt;
        unique case (last.kind)
            mie_pkg::KIND_MUL:
            begin
                r_data.lo_value     = mie_pkg::sext32(last.value[31:0]);
                r_data.hi_value     = mie_pkg::sext32(last.value[63:32]);
                r_data.result       = mie_pkg::sext32(last.value[31:0]);
                r_data.write_result = 1'b1;
                r_data.write_lohi   = 1'b1;
            end
            mie_pkg::KIND_DIV:
            begin
                r_data.lo_value   = mie_pkg::sext32(q);
                r_data.hi_value   = mie_pkg::sext32(r);
                r_data.write_lohi = 1'b1;
            end
            default:
            begin
                r_data.result       = last.value;
                r_data.write_result = 1'b1;
            end
        endcase
    end
endmodule

// ===== hw/rtl/mips_integer_alu_execute_unit.sv =====
`timescale 1ns / 1ps
// Integer execute unit: one item per instruction in, one result item out, in
// order. Takes a new item every cycle while the result queue has room. From
// push to the head of the result queue an item passes one classify stage,
// one queue slot, a multiply/operand stage and 32 one-bit divide stages that
// every item walks so that order is kept. Throughput is one item per cycle,
// set by the 32-stage divide pipeline; a full result queue stalls the
// whole back end.
module mips_integer_alu_execute_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    // item input
    input  logic               push,
    output logic               full,
    input  logic [3:0]         mode,
    input  logic signed [63:0] rs_value,
    input  logic signed [63:0] rt_value,
    input  logic [4:0]         shift_amount,
    input  logic [15:0]        immediate,
    // result output
    output logic               empty,
    input  logic               pop,
    output logic signed [63:0] result,
    output logic               write_result,
    output logic               dest_is_rt,
    output logic               write_lohi,
    output logic signed [63:0] lo_value,
    output logic signed [63:0] hi_value
);
    mie_pkg::fe_item_t  fq_wdata, fq_rdata;
    mie_pkg::res_item_t rq_wdata, rq_rdata;
    logic               fq_push, fq_full, fq_pop, fq_empty;
    logic               rq_push, rq_full;

    // front: classify, do all ops but multiply and divide
    mie_front u_front (
        .clk, .rst_n, .push, .full, .mode, .rs_value, .rt_value,
        .shift_amount, .immediate,
        .q_push (fq_push),
        .q_data (fq_wdata),
        .q_full (fq_full)
    );

    // decoupling queue between front and back
    mie_fifo #(.W($bits(mie_pkg::fe_item_t)), .DEPTH(QUEUE_DEPTH)) u_mid_q (
        .clk, .rst_n,
        .push    (fq_push),
        .wr_data (fq_wdata),
        .full    (fq_full),
        .pop     (fq_pop),
        .rd_data (fq_rdata),
        .empty   (fq_empty)
    );

    // back: multiply, divide, result assembly
    mie_back u_back (
        .clk, .rst_n,
        .q_empty (fq_empty),
        .q_data  (fq_rdata),
        .q_pop   (fq_pop),
        .r_push  (rq_push),
        .r_data  (rq_wdata),
        .r_full  (rq_full)
    );

    // result queue
    mie_fifo #(.W($bits(mie_pkg::res_item_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
        .clk, .rst_n,
        .push    (rq_push),
        .wr_data (rq_wdata),
        .full    (rq_full),
        .pop     (pop),
        .rd_data (rq_rdata),
        .empty   (empty)
    );

    assign result       = rq_rdata.result;
    assign write_result = rq_rdata.write_result;
    assign dest_is_rt   = rq_rdata.dest_is_rt;
    assign write_lohi   = rq_rdata.write_lohi;
    assign lo_value     = rq_rdata.lo_value;
    assign hi_value     = rq_rdata.hi_value;
endmodule

// ===== hw/rtl/mie_checker.sv =====
`timescale 1ns / 1ps
module mie_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [63:0] result,
    input logic        write_result,
    input logic        dest_is_rt,
    input logic        write_lohi,
    input logic [63:0] lo_value,
    input logic [63:0] hi_value
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result) && $stable(lo_value)))
        else $error("waiting item changed");

    a_no_lohi: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !write_lohi) |-> (lo_value == 64'd0 && hi_value == 64'd0))
        else $error("lo/hi set without update");

    a_rt_dest: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && dest_is_rt) |-> (write_result && !write_lohi))
        else $error("rt destination on wrong kind");

    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !write_result) |-> (result == 64'd0 && write_lohi))
        else $error("divide item has result");
endmodule

bind mips_integer_alu_execute_unit mie_checker u_mie_checker (
    .clk, .rst_n, .empty, .pop, .result, .write_result, .dest_is_rt,
    .write_lohi, .lo_value, .hi_value
);

// ===== dv/mips_integer_alu_execute_unit_test.sv =====
`timescale 1ns / 1ps
module mips_integer_alu_execute_unit_test;

    // expected result item
    typedef struct {
        logic [63:0] result;
        logic        write_result;
        logic        dest_is_rt;
        logic        write_lohi;
        logic [63:0] lo_value;
        logic [63:0] hi_value;
    } alu_out_t;

    // Golden ALU: works out the outcome of each accepted item and checks the
    // unit's results against them in order.
    class alu_scoreboard;
        alu_out_t pending[$];
        int       errors;

        static function logic [63:0] sx(input logic [31:0] w);
            return {{32{w[31]}}, w};
        endfunction

        function void note_item(input logic [3:0] op, input logic [63:0] rs,
                                input logic [63:0] rt, input logic [4:0] sa,
                                input logic [15:0] imm);
            alu_out_t    o;
            logic [31:0] a, b, q, r, ma, mb;
            logic [63:0] p;
            logic [4:0]  vsh;
            a = rs[31:0];
            b = rt[31:0];
            vsh = rs[4:0];
            o.result = '0;
            o.write_result = 1'b1;
            o.dest_is_rt = 1'b0;
            o.write_lohi = 1'b0;
            o.lo_value = '0;
            o.hi_value = '0;
            case (op)
                mie_pkg::MODE_MULT, mie_pkg::MODE_MULTU:
                begin
                    if (op == mie_pkg::MODE_MULT)
                        p = sx(a) * sx(b);
                    else
                        p = {32'd0, a} * {32'd0, b};
                    o.lo_value = sx(p[31:0]);
                    o.hi_value = sx(p[63:32]);
                    o.result = o.lo_value;
                    o.write_lohi = 1'b1;
                end
                mie_pkg::MODE_DIV:
                begin
                    o.write_result = 1'b0;
                    o.write_lohi = 1'b1;
                    if (a == 32'h8000_0000 && b == 32'hffff_ffff)
                        o.lo_value = sx(32'h8000_0000);
                    else if (b == 0)
                    begin
                        o.lo_value = a[31] ? 64'd1 : '1;
                        o.hi_value = sx(a);
                    end
                    else
                    begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q = ma / mb;
                        r = ma % mb;
                        if (a[31] != b[31])
                            q = -q;
                        if (a[31])
                            r = -r;
                        o.lo_value = sx(q);
                        o.hi_value = sx(r);
                    end
                end
                mie_pkg::MODE_DIVU:
                begin
                    o.write_result = 1'b0;
                    o.write_lohi = 1'b1;
                    if (b == 0)
                    begin
                        o.lo_value = '1;
                        o.hi_value = sx(a);
                    end
                    else
                    begin
                        o.lo_value = sx(a / b);
                        o.hi_value = sx(a % b);
                    end
                end
                mie_pkg::MODE_ADD, mie_pkg::MODE_ADDU: o.result = sx(a + b);
                mie_pkg::MODE_SUB, mie_pkg::MODE_SUBU: o.result = sx(a - b);
                mie_pkg::MODE_ORI:
                begin
                    o.result = rs | {48'd0, imm};
                    o.dest_is_rt = 1'b1;
                end
                mie_pkg::MODE_XORI:
                begin
                    o.result = rs ^ {48'd0, imm};
                    o.dest_is_rt = 1'b1;
                end
                mie_pkg::MODE_SLT:
                    o.result = ($signed(rs) < $signed(rt)) ? 64'd1 : 64'd0;
                mie_pkg::MODE_SLL: o.result = sx(b << sa);
                mie_pkg::MODE_SRL: o.result = sx(b >> sa);
                mie_pkg::MODE_SRA: o.result = sx($signed(b) >>> sa);
                mie_pkg::MODE_SLLV: o.result = sx(b << vsh);
                default: o.result = sx(b >> vsh);
            endcase
            pending.push_back(o);
        endfunction

        function void check_result(input logic [63:0] res, input logic wres,
                                   input logic drt, input logic wlh,
                                   input logic [63:0] lo, input logic [63:0] hi);
            alu_out_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: result with none expected, result %h", $time, res);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (res !== e.result)
            begin
                $display("%0t: result exp %h got %h", $time, e.result, res);
                errors++;
            end
            if (wres !== e.write_result)
            begin
                $display("%0t: write_result exp %b got %b", $time, e.write_result, wres);
                errors++;
            end
            if (drt !== e.dest_is_rt)
            begin
                $display("%0t: dest_is_rt exp %b got %b", $time, e.dest_is_rt, drt);
                errors++;
            end
            if (wlh !== e.write_lohi)
            begin
                $display("%0t: write_lohi exp %b got %b", $time, e.write_lohi, wlh);
                errors++;
            end
            if (lo !== e.lo_value)
            begin
                $display("%0t: lo_value exp %h got %h", $time, e.lo_value, lo);
                errors++;
            end
            if (hi !== e.hi_value)
            begin
                $display("%0t: hi_value exp %h got %h", $time, e.hi_value, hi);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [3:0]         mode = '0;
    logic signed [63:0] rs_value = '0;
    logic signed [63:0] rt_value = '0;
    logic [4:0]         shift_amount = '0;
    logic [15:0]        immediate = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [63:0] result;
    logic               write_result;
    logic               dest_is_rt;
    logic               write_lohi;
    logic signed [63:0] lo_value;
    logic signed [63:0] hi_value;

    alu_scoreboard board = new();
    bit            feed_done = 1'b0;

    always #10 clk = ~clk;

    mips_integer_alu_execute_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .rs_value     (rs_value),
        .rt_value     (rt_value),
        .shift_amount (shift_amount),
        .immediate    (immediate),
        .empty        (empty),
        .pop          (pop),
        .result       (result),
        .write_result (write_result),
        .dest_is_rt   (dest_is_rt),
        .write_lohi   (write_lohi),
        .lo_value     (lo_value),
        .hi_value     (hi_value)
    );

    function automatic logic [63:0] sx32_of(input logic [31:0] w);
        return {{32{w[31]}}, w};
    endfunction

    // 64-bit value with a bias towards the awkward corners
    function automatic logic [63:0] pick_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: w = '0;
            1: w = '1;
            2: w = sx32_of(32'h8000_0000);
            3: w = {$urandom, 32'h8000_0000};
            4: w = {32'd0, $urandom};
            5: w = 64'(int'($urandom_range(0, 20)) - 10);
            6: w = {$urandom, 32'hffff_ffff};
            default: ;
        endcase
        return w;
    endfunction

    // present one item and hold it until accepted; an idle gap goes first
    task automatic send_item(input logic [3:0] op, input logic [63:0] rs,
                             input logic [63:0] rt, input logic [4:0] sa,
                             input logic [15:0] imm, input int gap);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode <= op;
        rs_value <= rs;
        rt_value <= rt;
        shift_amount <= sa;
        immediate <= imm;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        board.note_item(op, rs, rt, sa, imm);
        @(negedge clk);
    endtask

    task automatic send_random(input int gap);
        send_item(4'($urandom_range(0, 15)), pick_word(), pick_word(),
                  5'($urandom), 16'($urandom), gap);
    endtask

    // stimulus
    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed: every operation at the field extremes and special cases
        send_item(mie_pkg::MODE_MULT, 64'hffff_ffff_8000_0000, 64'h8000_0000,
                  5'd0, 16'd0, 0);
        send_item(mie_pkg::MODE_MULTU, '1, '1, 5'd31, 16'hffff, 0);
        // overflow
        send_item(mie_pkg::MODE_DIV, 64'h8000_0000, '1, 5'd0, 16'd0, 0);
        // by zero, pos
        send_item(mie_pkg::MODE_DIV, 64'd1234, 64'd0, 5'd0, 16'd0, 0);
        // by zero, neg
        send_item(mie_pkg::MODE_DIV, 64'hffff_ffff_ffff_fff9, 64'd0, 5'd0, 16'd0, 0);
        send_item(mie_pkg::MODE_DIV, 64'hffff_ffff_ffff_fff9, 64'd2, 5'd0, 16'd0, 0);
        send_item(mie_pkg::MODE_DIVU, 64'hffff_ffff, 64'd0, 5'd0, 16'd0, 0);
        send_item(mie_pkg::MODE_DIVU, 64'hffff_ffff, 64'h7, 5'd0, 16'd0, 0);
        send_item(mie_pkg::MODE_ADD, 64'h7fff_ffff, 64'd1, 5'd0, 16'd0, 0);
        send_item(mie_pkg::MODE_ADDU, '1, 64'd1, 5'd0, 16'd0, 0);
        send_item(mie_pkg::MODE_SUB, 64'h8000_0000, 64'd1, 5'd0, 16'd0, 0);
        send_item(mie_pkg::MODE_SUBU, 64'd0, 64'd1, 5'd0, 16'd0, 0);
        send_item(mie_pkg::MODE_ORI, 64'h8000_0000_0000_0000, 64'd0, 5'd0, 16'hffff, 0);
        send_item(mie_pkg::MODE_XORI, '1, 64'd0, 5'd0, 16'hffff, 0);
        send_item(mie_pkg::MODE_SLT, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
                  5'd0, 16'd0, 0);
        send_item(mie_pkg::MODE_SLT, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
                  5'd0, 16'd0, 0);
        send_item(mie_pkg::MODE_SLL, 64'd0, 64'h1, 5'd31, 16'd0, 0);
        send_item(mie_pkg::MODE_SRL, 64'd0, 64'h8000_0000, 5'd31, 16'd0, 0);
        send_item(mie_pkg::MODE_SRA, 64'd0, 64'h8000_0000, 5'd31, 16'd0, 0);
        send_item(mie_pkg::MODE_SLLV, 64'h3f, 64'hffff_ffff, 5'd0, 16'd0, 0);
        send_item(mie_pkg::MODE_SRLV, 64'h21, 64'h8000_0000, 5'd0, 16'd0, 0);
        // zero source
        send_item(mie_pkg::MODE_SRLV, 64'h4, 64'd0, 5'd0, 16'd0, 0);
        // random: back-to-back stretches, random gaps elsewhere
        for (int i = 0; i < 800; i++)
        begin
            if (i == 400)
            begin
                // drain fully before carrying on
                push <= 1'b0;
                wait (board.pending.size() == 0);
                @(negedge clk);
            end
            send_random((i < 150 || (i >= 500 && i < 600)) ? 0 : $urandom_range(0, 6));
        end
        push <= 1'b0;
        feed_done = 1'b1;
    end

    // result side: random stalls with a no-stall stretch
    initial
    begin
        int n;
        int gap;
        n = 0;
        @(posedge rst_n);
        forever
        begin
            gap = (n >= 200 && n < 350) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            board.check_result(result, write_result, dest_is_rt, write_lohi,
                               lo_value, hi_value);
            n++;
            @(negedge clk);
        end
    end

    // end of run
    initial
    begin
        wait (feed_done);
        wait (board.pending.size() == 0);
        repeat (60) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("mips_integer_alu_execute_unit_test: done, clean");
        else
            $display("mips_integer_alu_execute_unit_test: done, errors");
        $finish;
    end

    // watchdog: worst case for ~830 items with the longest gaps on both sides, taken well over
    initial
    begin
        #5_000_000;
        $display("mips_integer_alu_execute_unit_test: done, errors");
        $finish;
    end

endmodule
